// File: src/aad_pkg.sv
package aad_pkg;

  // Alphabet and table geometry
  localparam int unsigned SYMBOLS      = 256;
  localparam int unsigned SYM_W        = 8;
  localparam int unsigned IDX_W        = 9;   // holds 0..SYMBOLS
  localparam int unsigned CUM_W        = 10;
  localparam int unsigned CNT_W        = 9;

  // Interval and code window
  localparam int unsigned CODE_BITS    = 64;
  localparam int unsigned WIN_BITS     = 32;
  localparam int unsigned FILL_W       = 6;
  localparam int unsigned WEIGHT_SHIFT = 9;
  localparam int unsigned Q_W          = CODE_BITS - WEIGHT_SHIFT;

  // Per-byte bookkeeping
  localparam int unsigned MAX_RESULTS  = 32;
  localparam int unsigned N_W          = 6;
  localparam int unsigned BITS_W       = 4;
  localparam int unsigned CFG_W        = 32;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_BIT,
    S_SCAN,
    S_DRAIN,
    S_UPDATE,
    S_EMIT,
    S_FLUSH
  } core_state_e;

  typedef enum logic [1:0] {
    T_INIT,
    T_IDLE,
    T_INC,
    T_RESCALE
  } tbl_state_e;

  // Core to table block: count one symbol, optionally rebuild the table after
  typedef struct packed {
    logic             inc_v;
    logic [SYM_W-1:0] inc_sel;
    logic             rescale;
  } tbl_req_t;

  // Core to output register
  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } out_beat_t;

endpackage

// File: src/aad_tables.sv
module aad_tables (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  aad_pkg::tbl_req_t         req_i,
  input  logic [aad_pkg::IDX_W-1:0] cum_raddr_i,
  output logic [aad_pkg::CUM_W-1:0] cum_rdata_o,
  output logic                      busy_o
);
  import aad_pkg::*;

  logic [CUM_W-1:0] cum_mem [SYMBOLS+1];
  logic [CNT_W-1:0] cnt_mem [SYMBOLS];

  tbl_state_e st_q, st_d;
  logic [IDX_W-1:0] ptr_q;
  logic [SYM_W-1:0] inc_sel_q;
  logic             rescale_q;
  logic             wv_q;
  logic [SYM_W-1:0] widx_q;
  logic [CUM_W-1:0] acc_q;
  logic [CNT_W-1:0] cnt_rdata_q;
  logic [CUM_W-1:0] cum_rdata_q;

  logic [SYM_W-1:0] cnt_raddr;
  logic             cnt_we;
  logic [SYM_W-1:0] cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata;
  logic             cum_we;
  logic [IDX_W-1:0] cum_waddr;
  logic [CUM_W-1:0] cum_wdata;
  logic [CUM_W-1:0] rs_sum;

  // Running sum for the rebuild: next boundary = previous + 1 + count
  assign rs_sum = acc_q + CUM_W'(1) + CUM_W'(cnt_rdata_q);

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      T_INIT:    if (ptr_q == IDX_W'(SYMBOLS)) st_d = T_IDLE;
      T_IDLE:    if (req_i.inc_v) st_d = T_INC;
      T_INC:     st_d = rescale_q ? T_RESCALE : T_IDLE;
      T_RESCALE: if (wv_q && widx_q == SYM_W'(SYMBOLS - 1)) st_d = T_IDLE;
      default:   st_d = T_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    cnt_raddr = req_i.inc_sel;
    cnt_we    = 1'b0;
    cnt_waddr = ptr_q[SYM_W-1:0];
    cnt_wdata = '0;
    cum_we    = 1'b0;
    cum_waddr = ptr_q;
    cum_wdata = CUM_W'({ptr_q, 1'b0});
    unique case (st_q)
      T_INIT: begin
        cum_we = 1'b1;
        cnt_we = (ptr_q < IDX_W'(SYMBOLS));
      end
      T_IDLE: begin
      end
      T_INC: begin
        cnt_we    = 1'b1;
        cnt_waddr = inc_sel_q;
        cnt_wdata = cnt_rdata_q + CNT_W'(1);
      end
      T_RESCALE: begin
        cnt_raddr = ptr_q[SYM_W-1:0];
        cnt_we    = wv_q;
        cnt_waddr = widx_q;
        cum_we    = wv_q;
        cum_waddr = IDX_W'(widx_q) + IDX_W'(1);
        cum_wdata = rs_sum;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= T_INIT;
      ptr_q     <= '0;
      wv_q      <= 1'b0;
      rescale_q <= 1'b0;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        T_INIT: ptr_q <= ptr_q + IDX_W'(1);
        T_IDLE: begin
          ptr_q     <= '0;
          wv_q      <= 1'b0;
          rescale_q <= req_i.rescale;
        end
        T_INC: ptr_q <= '0;
        T_RESCALE: begin
          wv_q <= (ptr_q < IDX_W'(SYMBOLS));
          if (ptr_q < IDX_W'(SYMBOLS)) ptr_q <= ptr_q + IDX_W'(1);
        end
        default: ptr_q <= '0;
      endcase
    end
  end

  // Sweep payload
  always_ff @(posedge clk_i) begin
    if (st_q == T_IDLE) inc_sel_q <= req_i.inc_sel;
    if (st_q == T_INC) acc_q <= '0;
    else if (st_q == T_RESCALE && wv_q) acc_q <= rs_sum;
    widx_q <= ptr_q[SYM_W-1:0];
  end

  // Count memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rdata_q <= cnt_mem[cnt_raddr];
  end

  // Cumulative table: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cum_we) cum_mem[cum_waddr] <= cum_wdata;
    cum_rdata_q <= cum_mem[cum_raddr_i];
  end

  assign cum_rdata_o = cum_rdata_q;
  assign busy_o      = (st_q != T_IDLE);

endmodule

// File: src/aad_scale.sv
module aad_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_v_i,
  input  logic [aad_pkg::IDX_W-1:0]     in_idx_i,
  input  logic [aad_pkg::CUM_W-1:0]     c_i,
  input  logic [aad_pkg::Q_W-1:0]       q_i,
  input  logic [aad_pkg::WEIGHT_SHIFT-1:0] r_i,
  input  logic                          full_i,
  output logic                          out_v_o,
  output logic [aad_pkg::IDX_W-1:0]     out_idx_o,
  output logic [aad_pkg::CODE_BITS-1:0] prod_o
);
  import aad_pkg::*;

  logic [Q_W+CUM_W-1:0]          qc;
  logic [WEIGHT_SHIFT+CUM_W-1:0] rc;
  logic [CODE_BITS-1:0]          prod_d;
  logic                          v_q;
  logic [IDX_W-1:0]              idx_q;
  logic [CODE_BITS-1:0]          prod_q;

  // width * c / total, split as q*c + (r*c >> shift); full range is a plain shift
  assign qc = (Q_W+CUM_W)'(q_i) * (Q_W+CUM_W)'(c_i);
  assign rc = (WEIGHT_SHIFT+CUM_W)'(r_i) * (WEIGHT_SHIFT+CUM_W)'(c_i);

  always_comb begin
    if (full_i) prod_d = {c_i[WEIGHT_SHIFT-1:0], {Q_W{1'b0}}};
    else prod_d = qc[CODE_BITS-1:0] + CODE_BITS'(rc[WEIGHT_SHIFT+CUM_W-1:WEIGHT_SHIFT]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else v_q <= in_v_i;
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= in_idx_i;
    prod_q <= prod_d;
  end

  assign out_v_o   = v_q;
  assign out_idx_o = idx_q;
  assign prod_o    = prod_q;

endmodule

// File: src/aad_core.sv
module aad_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [7:0]                in_byte_i,
  output logic                      in_ready_o,
  input  logic [aad_pkg::CFG_W-1:0] sym_count_i,
  input  logic                      out_free_i,
  output aad_pkg::out_beat_t        out_o,
  output aad_pkg::tbl_req_t         tbl_req_o,
  input  logic                      tbl_busy_i,
  output logic [aad_pkg::IDX_W-1:0] cum_raddr_o,
  input  logic [aad_pkg::CUM_W-1:0] cum_rdata_i
);
  import aad_pkg::*;

  core_state_e st_q, st_d;

  logic [CODE_BITS-1:0] low_q, high_q;
  logic [WIN_BITS-1:0]  win_q;
  logic [FILL_W-1:0]    fill_q;
  logic [CFG_W-1:0]     dec_q;
  logic [7:0]           byte_q;
  logic [BITS_W-1:0]    bits_q;
  logic [N_W-1:0]       n_q;
  logic [IDX_W-1:0]     ra_q;
  logic [Q_W-1:0]       q_q;
  logic [WEIGHT_SHIFT-1:0] r_q;
  logic                 full_q;
  logic [SYM_W-1:0]     sel_q;
  logic [CODE_BITS-1:0] lo_b_q, hi_b_q;
  logic                 hold_v_q;
  logic [SYM_W-1:0]     hold_sym_q;
  logic                 rd_v_q;
  logic [IDX_W-1:0]     rd_idx_q;

  logic                 sc_v;
  logic [IDX_W-1:0]     sc_idx;
  logic [CODE_BITS-1:0] sc_prod;
  logic [CODE_BITS-1:0] bound;
  logic [CODE_BITS-1:0] target;
  logic [CODE_BITS-1:0] span, span_p1;
  logic                 shift_out, shift_mid, pending, dec_ok, in_bit;

  // Renormalization conditions
  assign shift_out = !high_q[CODE_BITS-1] || low_q[CODE_BITS-1];
  assign shift_mid = low_q[CODE_BITS-2] && !high_q[CODE_BITS-2];
  assign pending   = shift_out || shift_mid;
  assign dec_ok    = (n_q < N_W'(MAX_RESULTS)) && (fill_q == FILL_W'(WIN_BITS))
                     && !pending && (dec_q < sym_count_i);
  assign in_bit    = byte_q[bits_q[2:0] - 3'd1];

  assign target  = {win_q, {(CODE_BITS-WIN_BITS){1'b0}}};
  assign span    = high_q - low_q;
  assign span_p1 = span + CODE_BITS'(1);
  assign bound   = low_q + sc_prod;

  aad_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_v_i    (rd_v_q),
    .in_idx_i  (rd_idx_q),
    .c_i       (cum_rdata_i),
    .q_i       (q_q),
    .r_i       (r_q),
    .full_i    (full_q),
    .out_v_o   (sc_v),
    .out_idx_o (sc_idx),
    .prod_o    (sc_prod)
  );

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE:   if (in_valid_i && !tbl_busy_i) st_d = S_CHECK;
      S_CHECK: begin
        if (dec_ok) begin
          if (!tbl_busy_i) st_d = S_SCAN;
        end else if (bits_q != '0) begin
          st_d = S_BIT;
        end else begin
          st_d = S_FLUSH;
        end
      end
      S_BIT:    st_d = S_CHECK;
      S_SCAN:   if (ra_q == IDX_W'(SYMBOLS)) st_d = S_DRAIN;
      S_DRAIN:  if (sc_v && sc_idx == IDX_W'(SYMBOLS)) st_d = S_UPDATE;
      S_UPDATE: st_d = S_EMIT;
      S_EMIT:   if (!hold_v_q || out_free_i) st_d = S_CHECK;
      S_FLUSH:  if (!hold_v_q || out_free_i) st_d = S_IDLE;
      default:  st_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o        = 1'b0;
    out_o             = '0;
    out_o.symbol      = hold_sym_q;
    tbl_req_o         = '0;
    tbl_req_o.inc_sel = sel_q;
    tbl_req_o.rescale = (dec_q[SYM_W-1:0] == '1);
    cum_raddr_o       = ra_q;
    unique case (st_q)
      S_IDLE:   in_ready_o = !tbl_busy_i;
      S_UPDATE: tbl_req_o.inc_v = 1'b1;
      S_EMIT:   out_o.valid = hold_v_q && out_free_i;
      S_FLUSH: begin
        out_o.valid = hold_v_q && out_free_i;
        out_o.last  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      low_q    <= '0;
      high_q   <= '1;
      win_q    <= '0;
      fill_q   <= '0;
      dec_q    <= '0;
      bits_q   <= '0;
      n_q      <= '0;
      ra_q     <= '0;
      hold_v_q <= 1'b0;
      rd_v_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      rd_v_q <= (st_q == S_SCAN);
      unique case (st_q)
        S_IDLE: begin
          bits_q <= BITS_W'(8);
          n_q    <= '0;
        end
        S_CHECK: ra_q <= IDX_W'(1);
        S_BIT: begin
          bits_q <= bits_q - BITS_W'(1);
          if (fill_q != FILL_W'(WIN_BITS)) begin
            win_q  <= {win_q[WIN_BITS-2:0], in_bit};
            fill_q <= fill_q + FILL_W'(1);
          end else if (shift_out) begin
            low_q  <= {low_q[CODE_BITS-2:0], 1'b0};
            high_q <= {high_q[CODE_BITS-2:0], 1'b1};
            win_q  <= {win_q[WIN_BITS-2:0], in_bit};
          end else if (shift_mid) begin
            // middle straddle: drop the second bit, flip the new top
            low_q  <= {~low_q[CODE_BITS-2], low_q[CODE_BITS-3:0], 1'b0};
            high_q <= {~high_q[CODE_BITS-2], high_q[CODE_BITS-3:0], 1'b1};
            win_q  <= {~win_q[WIN_BITS-2], win_q[WIN_BITS-3:0], in_bit};
          end
        end
        S_SCAN: ra_q <= ra_q + IDX_W'(1);
        S_DRAIN: begin
        end
        S_UPDATE: begin
          low_q  <= lo_b_q;
          high_q <= hi_b_q - CODE_BITS'(1);
          dec_q  <= dec_q + CFG_W'(1);
        end
        S_EMIT: if (!hold_v_q || out_free_i) begin
          hold_v_q <= 1'b1;
          n_q      <= n_q + N_W'(1);
        end
        S_FLUSH: if (out_free_i) hold_v_q <= 1'b0;
        default: begin
        end
      endcase
    end
  end

  // Search payload: scale setup, slot compare, held result
  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE) byte_q <= in_byte_i;
    rd_idx_q <= ra_q;
    if (st_q == S_CHECK) begin
      q_q    <= span_p1[CODE_BITS-1:WEIGHT_SHIFT];
      r_q    <= span_p1[WEIGHT_SHIFT-1:0];
      full_q <= (span == '1);
      sel_q  <= '0;
      lo_b_q <= low_q;
    end else if (sc_v) begin
      if (!sc_idx[IDX_W-1] && bound <= target) begin
        sel_q  <= sc_idx[SYM_W-1:0];
        lo_b_q <= bound;
      end
      if (IDX_W'(sel_q) + IDX_W'(1) == sc_idx) hi_b_q <= bound;
    end
    if (st_q == S_EMIT && (!hold_v_q || out_free_i)) hold_sym_q <= sel_q;
  end

endmodule

// File: src/adaptive_arithmetic_decoder.sv
// Adaptive arithmetic decoder: compressed bytes enter on the s_axis side, most
// significant bit first, and decoded byte symbols leave on the m_axis side; tlast
// marks the last symbol that a byte released. Each bit passes a check and a shift
// step, and each decoded symbol runs a slot search that streams cumulative-table
// entries 1 to 256 out of a one-port-read memory, one per cycle, through a
// registered scaling multiplier. Every 256th symbol starts a table rebuild that
// holds off the next search. After reset a pass loads the tables, during which
// s_axis_tready stays low. cfg_data_i sets how many symbols to decode; write it
// only while the block is idle.
module adaptive_arithmetic_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] code_byte
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [7:0] symbol
  output logic                      m_axis_tlast,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [aad_pkg::CFG_W-1:0] cfg_data_i
);
  import aad_pkg::*;

  logic [CFG_W-1:0] sym_count_q;
  logic             m_valid_q;
  logic [SYM_W-1:0] m_data_q;
  logic             m_last_q;
  logic             out_free;
  out_beat_t        out_beat;
  tbl_req_t         tbl_req;
  logic             tbl_busy;
  logic [IDX_W-1:0] cum_raddr;
  logic [CUM_W-1:0] cum_rdata;

  aad_tables u_tables (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (tbl_req),
    .cum_raddr_i (cum_raddr),
    .cum_rdata_o (cum_rdata),
    .busy_o      (tbl_busy)
  );

  aad_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata),
    .in_ready_o  (s_axis_tready),
    .sym_count_i (sym_count_q),
    .out_free_i  (out_free),
    .out_o       (out_beat),
    .tbl_req_o   (tbl_req),
    .tbl_busy_i  (tbl_busy),
    .cum_raddr_o (cum_raddr),
    .cum_rdata_i (cum_rdata)
  );

  // Symbol count register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sym_count_q <= '0;
    else if (cfg_valid_i) sym_count_q <= cfg_data_i;
  end

  // Output register
  assign out_free = !m_valid_q || m_axis_tready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_valid_q <= 1'b0;
    else if (out_beat.valid) m_valid_q <= 1'b1;
    else if (m_axis_tready) m_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_beat.valid) begin
      m_data_q <= out_beat.symbol;
      m_last_q <= out_beat.last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// File: src/aad_checker.sv
module aad_assert (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // A stalled output beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  // One byte at a time: ready drops right after a beat is taken
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a byte is in work");

  // Eight bit steps keep the input closed for a while
  a_in_busy_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> ##8 !s_axis_tready)
    else $error("byte finished too early");

  // The table load after reset keeps the input closed
  a_init: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input open during table load");

endmodule

bind adaptive_arithmetic_decoder aad_assert u_aad_assert (.*);

// File: tb/aad_checker.sv
`timescale 1ns / 100ps

// Watches the code-byte, symbol and config channels, predicts symbols from the
// accepted bytes and compares each symbol beat with the oldest prediction.
module aad_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [7:0]                m_axis_tdata,
  input  logic                      m_axis_tlast,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_o,
  input  logic [aad_pkg::CFG_W-1:0] cfg_data_i,
  output int                        fail_count_o,
  output int                        pending_o
);
  import aad_pkg::*;

  localparam logic [63:0] HALF_C    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QUARTER_C = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } sym_beat_t;

  logic [63:0]      lo_q, hi_q;
  logic [31:0]      win_q;
  int unsigned      fill_q;
  logic [CUM_W-1:0] cum_q [SYMBOLS+1];
  logic [CNT_W-1:0] cnt_q [SYMBOLS];
  logic [31:0]      done_q, limit_q;
  sym_beat_t        expected_syms [$];
  int               fails;

  assign fail_count_o = fails;

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    fails++;
  endtask

  // width * c / 512, exact within 64 bits
  function automatic logic [63:0] scale_weight(input logic [CUM_W-1:0] c);
    logic [63:0]  span, d, q, r;
    logic [127:0] prod;
    span = hi_q - lo_q;
    if (span == '1) return {c[WEIGHT_SHIFT-1:0], 55'd0};
    d = span + 64'd1;
    q = d >> WEIGHT_SHIFT;
    r = d & 64'd511;
    prod = q * c;
    return prod[63:0] + ((r * c) >> WEIGHT_SHIFT);
  endfunction

  function automatic bit needs_shift();
    if (hi_q < HALF_C || lo_q >= HALF_C) return 1;
    return lo_q >= QUARTER_C && hi_q < HALF_C + QUARTER_C;
  endfunction

  task automatic shift_in(input logic b);
    if (hi_q < HALF_C || lo_q >= HALF_C) begin
      lo_q  = lo_q << 1;
      hi_q  = (hi_q << 1) | 64'd1;
      win_q = {win_q[30:0], b};
    end else if (lo_q >= QUARTER_C && hi_q < HALF_C + QUARTER_C) begin
      lo_q  = (lo_q << 1) - HALF_C;
      hi_q  = (hi_q << 1) - HALF_C + 64'd1;
      win_q = {win_q[30:0], b} ^ 32'h8000_0000;
    end
  endtask

  task automatic decode_symbol(output logic [7:0] sym);
    logic [63:0] tgt, nlo, nhi;
    int          sel;
    logic [CUM_W-1:0] acc;
    sel = 0;
    tgt = {win_q, 32'd0};
    for (int i = 1; i < SYMBOLS; i++)
      if (lo_q + scale_weight(cum_q[i]) <= tgt) sel = i;
    nlo = lo_q + scale_weight(cum_q[sel]);
    nhi = lo_q + scale_weight(cum_q[sel+1]) - 64'd1;
    lo_q = nlo;
    hi_q = nhi;
    cnt_q[sel] = cnt_q[sel] + 1'b1;
    done_q++;
    // table rebuild every 256 symbols
    if (done_q[7:0] == 8'd0) begin
      acc = '0;
      cum_q[0] = '0;
      for (int i = 1; i <= SYMBOLS; i++) begin
        acc = acc + 1'b1 + cnt_q[i-1];
        cum_q[i] = acc;
        cnt_q[i-1] = '0;
      end
    end
    sym = sel[7:0];
  endtask

  task automatic drain_symbols(inout int n);
    logic [7:0] s;
    while (n < MAX_RESULTS && fill_q >= WIN_BITS && !needs_shift() && done_q < limit_q) begin
      decode_symbol(s);
      expected_syms.push_back('{symbol: s, last: 1'b0});
      n++;
    end
  endtask

  task automatic predict_byte(input logic [7:0] cb);
    int n;
    n = 0;
    drain_symbols(n);
    for (int k = 7; k >= 0; k--) begin
      if (fill_q < WIN_BITS) begin
        win_q = {win_q[30:0], cb[k]};
        fill_q++;
      end else if (needs_shift()) begin
        shift_in(cb[k]);
      end
      drain_symbols(n);
    end
    if (n > 0) expected_syms[expected_syms.size()-1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sym_beat_t e;
    if (!rst_ni) begin
      lo_q = '0; hi_q = '1; win_q = '0; fill_q = 0;
      done_q = '0; limit_q = '0; fails = 0;
      for (int i = 0; i <= SYMBOLS; i++) cum_q[i] = CUM_W'(2 * i);
      for (int i = 0; i < SYMBOLS; i++) cnt_q[i] = '0;
      expected_syms.delete();
    end else begin
      // output beat first: it was produced by earlier bytes
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_syms.size() == 0) begin
          report($sformatf("unexpected symbol %0d", m_axis_tdata));
        end else begin
          e = expected_syms.pop_front();
          if (m_axis_tdata !== e.symbol)
            report($sformatf("symbol %0d, want %0d", m_axis_tdata, e.symbol));
          if (m_axis_tlast !== e.last)
            report($sformatf("tlast %0b, want %0b", m_axis_tlast, e.last));
        end
      end
      if (cfg_valid_i && cfg_ready_o) limit_q = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata);
    end
    pending_o = expected_syms.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import aad_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 20_000_000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;
  logic             m_axis_tlast;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i = '0;
  int               fail_count, pending;
  int unsigned      cycle_count = 0;
  bit               steady = 0;   // no idling while set

  always #6 clk_i = ~clk_i;

  adaptive_arithmetic_decoder DUT (.*);

  aad_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // symbol sink stalls about 6% of cycles
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 6);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // valid stays up between back-to-back beats; idle cycles drop it
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic set_symbol_count(input logic [CFG_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [7:0] dir_bytes [12] = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h80, 8'h01,
                                   8'h7F, 8'hFE, 8'h00, 8'hFF, 8'h3C, 8'hC3};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stopped decoder: symbol count zero, bytes fill window and are ignored
    set_symbol_count(32'd0);
    for (int i = 0; i < 6; i++) send_byte(dir_bytes[i]);
    wait_drained();
    // raised count resumes decoding; extremes and alternating patterns
    set_symbol_count(32'd40);
    for (int i = 6; i < 12; i++) send_byte(dir_bytes[i]);
    for (int i = 0; i < 6; i++) send_byte(dir_bytes[i]);
    wait_drained();
    // large count, then random bytes across all bit positions
    set_symbol_count(32'hFFFF_FFFF);
    for (int i = 0; i < 120; i++) send_byte(8'($urandom));
    // pause until every symbol has come out
    wait_drained();
    steady = 1;
    for (int i = 0; i < 60; i++) send_byte(8'($urandom));
    steady = 0;
    wait_drained();
    set_symbol_count(32'd700);
    for (int i = 0; i < 120; i++) send_byte(8'($urandom));
    wait_drained();
    set_symbol_count(32'hFFFF_FFFF);
    for (int i = 0; i < 60; i++) send_byte($urandom_range(1) ? 8'h00 : 8'($urandom));
    wait_drained();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
